/* rtl/gbh_pkg.sv */
package gbh_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 2048;
  localparam int unsigned COUNT_BITS_DEF = 32;
  localparam int unsigned BIN_COUNT      = 256;
  localparam int unsigned BIN_W          = 8;
  localparam int unsigned PIX_W          = 8;
  localparam int unsigned ROW_W          = 12;
  localparam int unsigned COL_W          = 11;
  localparam int unsigned HEIGHT_W       = 13;
  localparam int unsigned WIDTH_REG_W    = 12;
  localparam int unsigned CFG_DATA_W     = 13;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned RES_COUNT_W    = 32;
  localparam int unsigned MIN_DIM        = 5;
  localparam int unsigned MAX_HEIGHT     = 4096;
  localparam int unsigned WIDTH_RESET    = 640;
  localparam int unsigned HEIGHT_RESET   = 480;

  localparam int unsigned MID_DEPTH  = 8;
  localparam int unsigned MID_LVL_W  = $clog2(MID_DEPTH + 1);
  localparam int unsigned OUT_DEPTH  = 4;
  localparam int unsigned OUT_LVL_W  = $clog2(OUT_DEPTH + 1);

  // sum / 273 == (sum * 122911) >> 25 for every sum below 123817
  localparam int unsigned ROW_SUM_W  = 15;
  localparam int unsigned SUM_W      = 17;
  localparam int unsigned DIV_MULT   = 122911;
  localparam int unsigned DIV_SHIFT  = 25;
  localparam int unsigned MULT_W     = 17;
  localparam int unsigned PROD_W     = SUM_W + MULT_W;
  localparam int unsigned TAP_W      = 6;

  localparam logic [TAP_W-1:0] TAP [5][5] = '{
    '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1},
    '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
    '{6'd7, 6'd26, 6'd41, 6'd26, 6'd7},
    '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
    '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1}
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1
  } cfg_idx_e;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_READ  = 1'b1
  } kind_e;

  typedef struct packed {
    logic             kind;
    logic [PIX_W-1:0] pix;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [BIN_W-1:0] bin;
  } mid_item_t;

  typedef struct packed {
    logic                   kind;
    logic [PIX_W-1:0]       pix;
    logic [ROW_W-1:0]       row;
    logic [COL_W-1:0]       col;
    logic [RES_COUNT_W-1:0] count;
  } out_item_t;

endpackage

/* rtl/gaussian5x5_blur_with_histogram.sv */
// 5x5 Gaussian blur with a histogram of the blurred values. Pixels enter in
// raster order; each interior pixel yields one result (value, center row and
// column) and bumps its histogram bin, border pixels yield nothing, and a
// read request yields one bin count, in order with the pixel results. One
// transaction per clock is taken while full is low; a result passes through
// four front stages, the mid queue, the histogram read-modify-write stage and
// the result queue on its way to the result ports. After reset the line store
// is cleared one column per cycle, and full stays high until every column is
// cleared; config writes are taken during that time. Beyond that, full rises
// only when the result side stops popping and the queues fill up.
module gaussian5x5_blur_with_histogram #(
  parameter int unsigned MAX_WIDTH  = gbh_pkg::MAX_WIDTH_DEF,
  parameter int unsigned COUNT_BITS = gbh_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [gbh_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [gbh_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             push,
  output logic                             full,
  input  logic                             req_type_i,
  input  logic [gbh_pkg::PIX_W-1:0]        pixel_value_i,
  input  logic [gbh_pkg::BIN_W-1:0]        bin_index_i,
  output logic                             empty,
  input  logic                             pop,
  output logic                             result_kind_o,
  output logic [gbh_pkg::PIX_W-1:0]        filtered_pixel_o,
  output logic [gbh_pkg::ROW_W-1:0]        center_row_o,
  output logic [gbh_pkg::COL_W-1:0]        center_col_o,
  output logic [gbh_pkg::RES_COUNT_W-1:0]  bin_count_o
);
  import gbh_pkg::*;

  logic                 clearing;
  logic                 mid_push, mid_pop, mid_empty, mid_full;
  mid_item_t            mid_in, mid_out;
  logic [MID_LVL_W-1:0] mid_level;
  logic                 out_push, out_full;
  out_item_t            out_in, out_head;
  logic [OUT_LVL_W-1:0] out_level;

  gbh_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .push_i       (push),
    .req_type_i   (req_type_i),
    .pixel_value_i(pixel_value_i),
    .bin_index_i  (bin_index_i),
    .full_o       (full),
    .clearing_o   (clearing),
    .mid_level_i  (mid_level),
    .mid_push_o   (mid_push),
    .mid_item_o   (mid_in)
  );

  gbh_fifo #(
    .WIDTH($bits(mid_item_t)),
    .DEPTH(MID_DEPTH)
  ) u_mid_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (mid_push),
    .wdata_i(mid_in),
    .pop_i  (mid_pop),
    .rdata_o(mid_out),
    .empty_o(mid_empty),
    .full_o (mid_full),
    .level_o(mid_level)
  );

  gbh_back #(
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mid_empty_i(mid_empty),
    .mid_item_i (mid_out),
    .mid_pop_o  (mid_pop),
    .out_level_i(out_level),
    .out_push_o (out_push),
    .out_item_o (out_in)
  );

  gbh_fifo #(
    .WIDTH($bits(out_item_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .wdata_i(out_in),
    .pop_i  (pop),
    .rdata_o(out_head),
    .empty_o(empty),
    .full_o (out_full),
    .level_o(out_level)
  );

  assign result_kind_o    = out_head.kind;
  assign filtered_pixel_o = out_head.pix;
  assign center_row_o     = out_head.row;
  assign center_col_o     = out_head.col;
  assign bin_count_o      = out_head.count;

  a_mid_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mid_push && mid_full)) else $error("mid queue overflow");
  a_out_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_push && out_full)) else $error("result queue overflow");
  a_full_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> full) else $error("input open during clear");

endmodule

/* rtl/gbh_ram.sv */
module gbh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* rtl/gbh_fifo.sv */
module gbh_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       empty_o,
  output logic                       full_o,
  output logic [$clog2(DEPTH+1)-1:0] level_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned LW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] buf_q [DEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [LW-1:0]    level_q;
  logic             do_push, do_pop;

  assign empty_o = (level_q == '0);
  assign full_o  = (level_q == LW'(DEPTH));
  assign level_o = level_q;
  assign rdata_o = buf_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      level_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      level_q <= level_q + LW'(do_push) - LW'(do_pop);
    end
  end

endmodule

/* rtl/gbh_front.sv */
module gbh_front #(
  parameter int unsigned MAX_WIDTH = gbh_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gbh_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [gbh_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            push_i,
  input  logic                            req_type_i,
  input  logic [gbh_pkg::PIX_W-1:0]       pixel_value_i,
  input  logic [gbh_pkg::BIN_W-1:0]       bin_index_i,
  output logic                            full_o,
  output logic                            clearing_o,
  input  logic [gbh_pkg::MID_LVL_W-1:0]   mid_level_i,
  output logic                            mid_push_o,
  output gbh_pkg::mid_item_t              mid_item_o
);
  import gbh_pkg::*;

  localparam int unsigned CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WUW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned WX  = (WUW > WIDTH_REG_W) ? WUW : WIDTH_REG_W;
  localparam int unsigned LW  = 4 * PIX_W;
  localparam int unsigned CRW = MID_LVL_W + 1;

  typedef struct packed {
    logic             is_rd;
    logic             emit;
    logic [BIN_W-1:0] bin;
    logic [ROW_W-1:0] crow;
    logic [COL_W-1:0] ccol;
  } meta_t;

  logic [WIDTH_REG_W-1:0] wreg_q;
  logic [HEIGHT_W-1:0]    hreg_q;
  logic [CW-1:0]          col_q;
  logic [ROW_W-1:0]       row_q;
  logic                   clr_q;
  logic [CW-1:0]          clr_addr_q;

  logic [WX-1:0]       wx, w_use, c_ext, c_next;
  logic [HEIGHT_W-1:0] h_use, r_step, r_next;
  logic [CW-1:0]       c0;
  logic [ROW_W-1:0]    r0;
  logic                col_wrap, accept, is_rd_in;
  meta_t               meta_in;

  logic             s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  meta_t            s1_q, s2_q, s3_q, s4_q;
  logic [PIX_W-1:0] s1_px_q;
  logic [CW-1:0]    s1_col_q;

  logic [LW-1:0]    line_rdata, line_wdata;
  logic             line_we;
  logic [CW-1:0]    line_waddr;

  logic [PIX_W-1:0]     win_q [5][5];
  logic [ROW_SUM_W-1:0] rsum_q [5];
  logic [ROW_SUM_W-1:0] rsum_d [5];
  logic [SUM_W-1:0]     sum_q;
  logic [PROD_W-1:0]    prod;
  logic [8:0]           quot;
  logic [PIX_W-1:0]     pix_out;
  logic [CRW-1:0]       occupancy;

  // frame geometry in use
  always_comb begin
    wx = WX'(wreg_q);
    if (wx < WX'(MIN_DIM)) begin
      w_use = WX'(MIN_DIM);
    end else if (wx > WX'(MAX_WIDTH)) begin
      w_use = WX'(MAX_WIDTH);
    end else begin
      w_use = wx;
    end
    if (hreg_q < HEIGHT_W'(MIN_DIM)) begin
      h_use = HEIGHT_W'(MIN_DIM);
    end else if (hreg_q > HEIGHT_W'(MAX_HEIGHT)) begin
      h_use = HEIGHT_W'(MAX_HEIGHT);
    end else begin
      h_use = hreg_q;
    end
  end

  // position of the incoming pixel and the counters after it
  always_comb begin
    c_ext    = WX'(col_q);
    col_wrap = (c_ext >= w_use);
    c0       = col_wrap ? '0 : col_q;
    r_step   = HEIGHT_W'(row_q) + HEIGHT_W'(col_wrap);
    r0       = (r_step >= h_use) ? '0 : r_step[ROW_W-1:0];
    c_next   = WX'(c0) + 1'b1;
    r_next   = HEIGHT_W'(r0) + 1'b1;
  end

  assign occupancy = CRW'(mid_level_i) + CRW'(s1_v_q) + CRW'(s2_v_q)
                   + CRW'(s3_v_q) + CRW'(s4_v_q);
  assign full_o     = clr_q || (occupancy >= CRW'(MID_DEPTH));
  assign clearing_o = clr_q;
  assign accept     = push_i && !full_o;
  assign is_rd_in   = (req_type_i == KIND_READ);

  always_comb begin
    meta_in.is_rd = is_rd_in;
    meta_in.emit  = !is_rd_in && (r0 >= ROW_W'(4)) && (WX'(c0) >= WX'(4));
    meta_in.bin   = bin_index_i;
    meta_in.crow  = r0 - ROW_W'(2);
    meta_in.ccol  = COL_W'(WX'(c0) - WX'(2));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wreg_q     <= WIDTH_REG_W'(WIDTH_RESET);
      hreg_q     <= HEIGHT_W'(HEIGHT_RESET);
      col_q      <= '0;
      row_q      <= '0;
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WIDTH:  wreg_q <= cfg_data_i[WIDTH_REG_W-1:0];
          CFG_HEIGHT: hreg_q <= cfg_data_i;
          default:    ;
        endcase
      end
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == CW'(MAX_WIDTH - 1)) begin
          clr_q <= 1'b0;
        end
      end
      if (accept && !is_rd_in) begin
        if (c_next >= w_use) begin
          col_q <= '0;
          row_q <= (r_next >= h_use) ? '0 : r_next[ROW_W-1:0];
        end else begin
          col_q <= c_next[CW-1:0];
          row_q <= r0;
        end
      end
    end
  end

  // line store: one word per column, slot 0 newest row
  assign line_we    = clr_q || (s1_v_q && !s1_q.is_rd);
  assign line_waddr = clr_q ? clr_addr_q : s1_col_q;
  assign line_wdata = clr_q ? '0 : {line_rdata[3*PIX_W-1:0], s1_px_q};

  gbh_ram #(
    .WIDTH(LW),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (line_we),
    .waddr_i(line_waddr),
    .wdata_i(line_wdata),
    .re_i   (accept && !is_rd_in),
    .raddr_i(c0),
    .rdata_o(line_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      for (int k = 0; k < 5; k++) begin
        for (int j = 0; j < 5; j++) begin
          win_q[k][j] <= '0;
        end
      end
    end else begin
      s1_v_q <= accept;
      s2_v_q <= s1_v_q && (s1_q.is_rd || s1_q.emit);
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      if (s1_v_q && !s1_q.is_rd) begin
        for (int k = 0; k < 5; k++) begin
          for (int j = 0; j < 4; j++) begin
            win_q[k][j] <= win_q[k][j+1];
          end
        end
        for (int k = 0; k < 4; k++) begin
          win_q[k][4] <= line_rdata[(3-k)*PIX_W +: PIX_W];
        end
        win_q[4][4] <= s1_px_q;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 5; k++) begin
      rsum_d[k] = '0;
      for (int j = 0; j < 5; j++) begin
        rsum_d[k] = rsum_d[k] + ROW_SUM_W'(TAP[k][j] * win_q[k][j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q     <= meta_in;
    s1_px_q  <= pixel_value_i;
    s1_col_q <= c0;
    s2_q     <= s1_q;
    s3_q     <= s2_q;
    s4_q     <= s3_q;
    rsum_q   <= rsum_d;
    sum_q    <= SUM_W'(rsum_q[0]) + SUM_W'(rsum_q[1]) + SUM_W'(rsum_q[2])
              + SUM_W'(rsum_q[3]) + SUM_W'(rsum_q[4]);
  end

  assign prod    = PROD_W'(sum_q) * PROD_W'(DIV_MULT);
  assign quot    = prod[DIV_SHIFT +: 9];
  assign pix_out = (quot > 9'd255) ? 8'd255 : quot[PIX_W-1:0];

  assign mid_push_o = s4_v_q;
  always_comb begin
    mid_item_o.kind = s4_q.is_rd;
    if (s4_q.is_rd) begin
      mid_item_o.pix = '0;
      mid_item_o.row = '0;
      mid_item_o.col = '0;
      mid_item_o.bin = s4_q.bin;
    end else begin
      mid_item_o.pix = pix_out;
      mid_item_o.row = s4_q.crow;
      mid_item_o.col = s4_q.ccol;
      mid_item_o.bin = pix_out;
    end
  end

  a_no_item_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !accept) else $error("item taken during line store clear");
  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && !s1_q.is_rd |-> WX'(s1_col_q) < WX'(MAX_WIDTH))
    else $error("column beyond line store");
  a_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occupancy <= CRW'(MID_DEPTH)) else $error("mid queue credit overrun");

endmodule

/* rtl/gbh_back.sv */
module gbh_back #(
  parameter int unsigned COUNT_BITS = gbh_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          mid_empty_i,
  input  gbh_pkg::mid_item_t            mid_item_i,
  output logic                          mid_pop_o,
  input  logic [gbh_pkg::OUT_LVL_W-1:0] out_level_i,
  output logic                          out_push_o,
  output gbh_pkg::out_item_t            out_item_o
);
  import gbh_pkg::*;

  localparam int unsigned LB  = (COUNT_BITS < RES_COUNT_W) ? COUNT_BITS : RES_COUNT_W;
  localparam int unsigned OLW = OUT_LVL_W + 1;

  logic                  b1_v_q;
  mid_item_t             b1_q;
  logic [BIN_COUNT-1:0]  vld_q;
  logic                  fwd_v_q;
  logic [BIN_W-1:0]      fwd_addr_q;
  logic [COUNT_BITS-1:0] fwd_data_q;
  logic [COUNT_BITS-1:0] rdata, cur, incd;
  logic                  issue, hit, we;

  assign issue     = !mid_empty_i && ((OLW'(out_level_i) + OLW'(b1_v_q)) < OLW'(OUT_DEPTH));
  assign mid_pop_o = issue;

  gbh_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(BIN_COUNT)
  ) u_hist_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(b1_q.bin),
    .wdata_i(incd),
    .re_i   (issue),
    .raddr_i(mid_item_i.bin),
    .rdata_o(rdata)
  );

  // the read issued last cycle missed the write made in that same cycle
  assign hit  = fwd_v_q && (fwd_addr_q == b1_q.bin);
  assign cur  = hit ? fwd_data_q : (vld_q[b1_q.bin] ? rdata : '0);
  assign incd = (cur == '1) ? cur : cur + 1'b1;
  assign we   = b1_v_q && (b1_q.kind == KIND_PIXEL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q  <= 1'b0;
      vld_q   <= '0;
      fwd_v_q <= 1'b0;
    end else begin
      b1_v_q  <= issue;
      fwd_v_q <= we;
      if (we) begin
        vld_q[b1_q.bin] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      b1_q <= mid_item_i;
    end
    fwd_addr_q <= b1_q.bin;
    fwd_data_q <= incd;
  end

  assign out_push_o = b1_v_q;
  always_comb begin
    out_item_o.kind  = b1_q.kind;
    out_item_o.pix   = b1_q.pix;
    out_item_o.row   = b1_q.row;
    out_item_o.col   = b1_q.col;
    out_item_o.count = (b1_q.kind == KIND_READ) ? RES_COUNT_W'(cur[LB-1:0]) : '0;
  end

  a_out_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> OLW'(out_level_i) + OLW'(b1_v_q) < OLW'(OUT_DEPTH))
    else $error("result queue overrun");
  a_bin_written_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |=> vld_q[$past(b1_q.bin)]) else $error("bin valid bit not set");
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> incd >= cur) else $error("bin count wrapped");

endmodule
